// ===== rtl/spmf_pkg.sv =====
// Package for the strict priority multi-level queue.
// Holds sizes, status and operation codes, and the level status struct.
// No dependencies.
`default_nettype none
package spmf_pkg;
	localparam int MAX_LEVELS = 8;
	localparam int LEVEL_DEPTH = 16;
	localparam int TAG_BITS = 16;
	localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
	localparam int IDX_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_NEXT = 2'd1;
	localparam logic [1:0] KIND_ERASE = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_NO_ENTRY = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_BAD_PRIO = 3'd4;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic full;
		logic empty;
	} lvl_stat_t;
endpackage
`default_nettype wire

// ===== rtl/spmf_level.sv =====
// One level of the queue: a shift chain of tag cells with a fill count.
// Push appends at the count; remove shifts every cell past the index down by one.
// Depends on spmf_pkg.
`default_nettype none
module spmf_level import spmf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic clear,
	input wire logic push,
	input wire logic [TAG_BITS-1:0] push_tag,
	input wire logic remove,
	input wire logic [IDX_W-1:0] remove_idx,
	output logic [TAG_BITS-1:0] head_tag,
	output lvl_stat_t stat
);
	logic [TAG_BITS-1:0] cell_q [LEVEL_DEPTH];
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (push && count_q != CNT_W'(LEVEL_DEPTH)) begin
			count_q <= count_q + 1'b1;
		end else if (remove && count_q != '0) begin
			count_q <= count_q - 1'b1;
		end
	end

	genvar g;
	generate
		for (g = 0; g < LEVEL_DEPTH; g++) begin : g_cell
			always_ff @(posedge clk) begin
				if (push && count_q == CNT_W'(g)) begin
					cell_q[g] <= push_tag;
				end else if (remove && IDX_W'(g) >= remove_idx && g < LEVEL_DEPTH - 1) begin
					cell_q[g] <= cell_q[(g < LEVEL_DEPTH - 1) ? g + 1 : g];
				end
			end
		end
	endgenerate

	assign head_tag = cell_q[0];
	assign stat.count = count_q;
	assign stat.full = (count_q == CNT_W'(LEVEL_DEPTH));
	assign stat.empty = (count_q == '0);
endmodule
`default_nettype wire

// ===== rtl/spmf_ctrl.sv =====
// Sequencer: decodes an item, walks levels from the top one per cycle to
// locate the target, and builds the result. Depends on spmf_pkg.
`default_nettype none
module spmf_ctrl import spmf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_go,
	input wire logic [1:0] kind,
	input wire logic [3:0] priority_req,
	input wire logic [7:0] position,
	input wire logic [3:0] nlev,
	input wire lvl_stat_t stat [MAX_LEVELS],
	input wire logic [TAG_BITS-1:0] head [MAX_LEVELS],
	input wire logic out_free,
	output logic busy,
	output logic done,
	output logic [2:0] res_status,
	output logic [TAG_BITS-1:0] res_tag,
	output logic [MAX_LEVELS-1:0] push_sel,
	output logic [MAX_LEVELS-1:0] rem_sel,
	output logic [IDX_W-1:0] rem_idx
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] kind_q;
	logic [8:0] rem_q;
	logic [LVL_W:0] lv_q;
	logic [2:0] status_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [LVL_W-1:0] cur;
	logic [8:0] cnt9;

	assign cur = LVL_W'(lv_q - 1'b1);
	assign cnt9 = 9'(stat[cur].count);
	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE) && out_free;
	assign res_status = status_q;
	assign res_tag = tag_q;

	always_comb begin
		push_sel = '0;
		rem_sel = '0;
		rem_idx = '0;
		if (in_go && kind == KIND_ADD && priority_req != '0 && priority_req <= nlev
				&& !stat[LVL_W'(priority_req - 1'b1)].full) begin
			push_sel[LVL_W'(priority_req - 1'b1)] = 1'b1;
		end
		if (state_q == S_SCAN && lv_q != '0) begin
			if (kind_q == KIND_NEXT && !stat[cur].empty) begin
				rem_sel[cur] = 1'b1;
			end else if (kind_q == KIND_ERASE && rem_q <= cnt9) begin
				rem_sel[cur] = 1'b1;
				rem_idx = IDX_W'(rem_q - 9'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_go) begin
						state_q <= (kind == KIND_NEXT || (kind == KIND_ERASE && position != '0))
							? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					if (lv_q == '0 || rem_sel != '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_go) begin
			kind_q <= kind;
			rem_q <= {1'b0, position};
			lv_q <= (LVL_W+1)'(nlev);
			tag_q <= '0;
			case (kind)
				KIND_ADD: begin
					if (priority_req == '0 || priority_req > nlev) begin
						status_q <= ST_BAD_PRIO;
					end else if (stat[LVL_W'(priority_req - 1'b1)].full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_OK;
					end
				end
				KIND_NEXT: status_q <= ST_EMPTY;
				KIND_ERASE: status_q <= ST_NO_ENTRY;
				default: status_q <= ST_OK;
			endcase
		end else if (state_q == S_SCAN && lv_q != '0) begin
			if (rem_sel != '0) begin
				status_q <= ST_OK;
				if (kind_q == KIND_NEXT) begin
					tag_q <= head[cur];
				end
			end else begin
				rem_q <= rem_q - cnt9;
				lv_q <= lv_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(rem_sel));
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(push_sel));
	assert property (@(posedge clk) disable iff (!arst_n)
		!(push_sel != '0 && rem_sel != '0)) else $error("push and remove together");
endmodule
`default_nettype wire

// ===== rtl/strict_priority_multi_fifo.sv =====
// Strict priority multi-level queue: one shift-chain FIFO per level.
// Add needs no level walk; next and erase (nonzero position) walk the levels.
// Items are taken one at a time: in_ready stays low until the result is passed on.
// The result register lets the level walk finish while the result waits.
// Reset clears all level counts and sets num_levels to MAX_LEVELS at once.
// Depends on spmf_pkg, spmf_level and spmf_ctrl.
`default_nettype none
module strict_priority_multi_fifo import spmf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [3:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] kind,
	input wire logic [3:0] priority_req,
	input wire logic [15:0] item_tag,
	input wire logic [7:0] position,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic [15:0] out_tag
);
	logic [3:0] nlev_q;
	lvl_stat_t stat [MAX_LEVELS];
	logic [TAG_BITS-1:0] head [MAX_LEVELS];
	logic [MAX_LEVELS-1:0] push_sel;
	logic [MAX_LEVELS-1:0] rem_sel;
	logic [IDX_W-1:0] rem_idx;
	logic busy;
	logic done;
	logic [2:0] res_status;
	logic [TAG_BITS-1:0] res_tag;
	logic in_go;
	logic out_free;

	assign in_ready = !busy;
	assign in_go = in_valid && !busy;
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nlev_q <= 4'(MAX_LEVELS);
		end else if (cfg_we) begin
			if (cfg_wdata == '0) begin
				nlev_q <= 4'd1;
			end else if (cfg_wdata > 4'(MAX_LEVELS)) begin
				nlev_q <= 4'(MAX_LEVELS);
			end else begin
				nlev_q <= cfg_wdata;
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < MAX_LEVELS; g++) begin : g_lvl
			spmf_level u_level (
				.clk(clk), .arst_n(arst_n), .clear(cfg_we),
				.push(push_sel[g]), .push_tag(item_tag[TAG_BITS-1:0]),
				.remove(rem_sel[g]), .remove_idx(rem_idx),
				.head_tag(head[g]), .stat(stat[g])
			);
		end
	endgenerate

	spmf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .kind(kind),
		.priority_req(priority_req), .position(position), .nlev(nlev_q),
		.stat(stat), .head(head), .out_free(out_free), .busy(busy), .done(done),
		.res_status(res_status), .res_tag(res_tag), .push_sel(push_sel),
		.rem_sel(rem_sel), .rem_idx(rem_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (done) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status <= res_status;
			out_tag <= 16'(res_tag);
		end
	end
endmodule
`default_nettype wire
